// ===== rtl/dht_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dht_pkg
// Shared types, widths and codes of the double hash table.
// ----------------------------------------------------------------------------
package dht_pkg;

  localparam int KEY_W       = 31;
  localparam int CMD_W       = 2;
  localparam int STATUS_W    = 3;
  localparam int SLOT_OUT_W  = 4;
  localparam int SIZE_W      = 5;
  localparam int PRIME_W     = 4;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 5;
  localparam int S_TDATA_W   = 40;
  localparam int M_TDATA_W   = 8;

  localparam int DEFAULT_CAPACITY = 16;

  localparam logic [SIZE_W-1:0]  RESET_TABLE_SIZE = 5'd10;
  localparam logic [PRIME_W-1:0] RESET_STEP_PRIME = 4'd7;

  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_SIZE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_PRIME = 1'b1;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_SEARCH = 2'd1,
    CMD_DELETE = 2'd2
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_INSERTED  = 3'd0,
    STS_FULL      = 3'd1,
    STS_FOUND     = 3'd2,
    STS_NOT_FOUND = 3'd3,
    STS_DELETED   = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    MARK_EMPTY   = 2'd0,
    MARK_USED    = 2'd1,
    MARK_DELETED = 2'd2
  } mark_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_REDUCE,
    ST_PROBE,
    ST_EVAL,
    ST_FINISH
  } state_t;

  typedef struct packed {
    mark_t             mark;
    logic [KEY_W-1:0]  key;
  } entry_t;

  typedef struct packed {
    logic [SIZE_W-1:0]  h1;
    logic [PRIME_W-1:0] rp;
  } hash_t;

endpackage : dht_pkg
`default_nettype wire

// ===== rtl/dht_hash_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dht_hash_unit
// Bit-serial reduction of a key by table size and step prime, one key bit
// per cycle for both moduli at once.
// ----------------------------------------------------------------------------
module dht_hash_unit
  import dht_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire logic [KEY_W-1:0]    key,
  input  wire logic [SIZE_W-1:0]   size,
  input  wire logic [PRIME_W-1:0]  prime,
  output logic                     done,
  output hash_t                    hash
);

  logic                busy;
  logic [SIZE_W-1:0]   cnt;
  logic [KEY_W-1:0]    key_sr;
  logic [SIZE_W-1:0]   rem_s;
  logic [PRIME_W-1:0]  rem_p;
  logic [SIZE_W:0]     t_s;
  logic [PRIME_W:0]    t_p;
  logic [SIZE_W-1:0]   rem_s_next;
  logic [PRIME_W-1:0]  rem_p_next;

  always_comb begin
    t_s = {rem_s, key_sr[KEY_W-1]};
    t_p = {rem_p, key_sr[KEY_W-1]};
    if (t_s >= {1'b0, size}) begin
      rem_s_next = SIZE_W'(t_s - {1'b0, size});
    end else begin
      rem_s_next = SIZE_W'(t_s);
    end
    if (t_p >= {1'b0, prime}) begin
      rem_p_next = PRIME_W'(t_p - {1'b0, prime});
    end else begin
      rem_p_next = PRIME_W'(t_p);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == SIZE_W'(KEY_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      key_sr <= key;
      rem_s  <= '0;
      rem_p  <= '0;
    end else if (busy) begin
      key_sr <= key_sr << 1;
      rem_s  <= rem_s_next;
      rem_p  <= rem_p_next;
    end
  end

  assign hash.h1 = rem_s;
  assign hash.rp = rem_p;

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy)) else $error("hash done without a running reduction");

  a_start_when_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> !busy) else $error("hash start while busy");

  a_rem_in_range: assert property (@(posedge clk) disable iff (rst)
    busy |=> (rem_s < size)) else $error("size remainder out of range");

endmodule : dht_hash_unit
`default_nettype wire

// ===== rtl/double_hash_table_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// double_hash_table_top
// Open-addressing hash table with double hashing: insert, search, delete.
//
//   channel  | dir | payload
//   ---------+-----+---------------------------------------------------------
//   s_axis   | in  | request: command, key
//   m_axis   | out | result: status, slot_index
//   cfg      | in  | register write: index, data
//
// A request is worked through serial hashing of the key, reduction of the step
// below the table size, a probe and an evaluation state for each of up to
// table_size probes, and a finish state that loads the result; an unused
// command goes straight to the finish state. After reset a clearing pass writes
// every slot empty with requests held off. A stalled result waits in the output
// register while the next is worked on.
// ----------------------------------------------------------------------------
module double_hash_table_top
  import dht_pkg::*;
#(
  parameter int CAPACITY = DEFAULT_CAPACITY
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  input  wire logic [S_TDATA_W-1:0]   s_tdata,    // [1:0] command, [32:2] key
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  output logic [M_TDATA_W-1:0]        m_tdata,    // [2:0] status, [6:3] slot_index
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam logic [SIZE_W-1:0] SIZE_MAX = SIZE_W'((CAPACITY < 31) ? CAPACITY : 31);
  localparam logic [IDX_W-1:0]  CLR_LAST = IDX_W'(CAPACITY - 1);

  state_t               state, state_next;
  logic [SIZE_W-1:0]    table_size;
  logic [PRIME_W-1:0]   step_prime;
  logic [SIZE_W-1:0]    eff_size;
  logic [PRIME_W-1:0]   eff_prime;

  cmd_t                 cmd_q;
  logic [KEY_W-1:0]     key_q;
  logic [SIZE_W-1:0]    size_q;
  logic [PRIME_W-1:0]   prime_q;
  logic [SIZE_W-1:0]    h2;
  logic [SIZE_W-1:0]    slot;
  logic [SIZE_W-1:0]    probe_cnt;
  status_t              status_q;
  logic [SIZE_W-1:0]    slot_res;
  logic [IDX_W-1:0]     clr_cnt;

  entry_t               mem [CAPACITY];
  entry_t               rd_entry;
  entry_t               wr_entry;
  logic [IDX_W-1:0]     slot_addr;
  logic [IDX_W-1:0]     wr_addr;
  logic                 mem_we;

  logic                 s_accept;
  logic [CMD_W-1:0]     in_cmd;
  logic [KEY_W-1:0]     in_key;
  logic                 in_cmd_ok;
  logic                 hash_start;
  logic                 hash_done;
  hash_t                hash;

  logic                 is_insert;
  logic                 eval_take;
  logic                 eval_match;
  logic                 eval_empty;
  logic                 eval_last;
  logic [SIZE_W:0]      slot_sum;
  logic [SIZE_W-1:0]    slot_adv;
  logic                 out_free;

  assign in_cmd    = s_tdata[CMD_W-1:0];
  assign in_key    = s_tdata[CMD_W+KEY_W-1:CMD_W];
  assign s_tready  = (state == ST_IDLE);
  assign s_accept  = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;
  assign out_free  = !m_tvalid || m_tready;

  always_comb begin
    case (in_cmd)
      CMD_INSERT, CMD_SEARCH, CMD_DELETE: in_cmd_ok = 1'b1;
      default:                            in_cmd_ok = 1'b0;
    endcase
  end

  assign hash_start = s_accept && in_cmd_ok;

  always_comb begin
    if (table_size < SIZE_W'(2)) begin
      eff_size = SIZE_W'(2);
    end else if (table_size > SIZE_MAX) begin
      eff_size = SIZE_MAX;
    end else begin
      eff_size = table_size;
    end
    eff_prime = (step_prime == '0) ? PRIME_W'(1) : step_prime;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      table_size <= RESET_TABLE_SIZE;
      step_prime <= RESET_STEP_PRIME;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_TABLE_SIZE: table_size <= cfg_data;
        CFG_STEP_PRIME: step_prime <= cfg_data[PRIME_W-1:0];
        default: ;
      endcase
    end
  end

  dht_hash_unit u_hash (
    .clk   (clk),
    .rst   (rst),
    .start (hash_start),
    .key   (in_key),
    .size  (eff_size),
    .prime (eff_prime),
    .done  (hash_done),
    .hash  (hash)
  );

  // probe evaluation
  always_comb begin
    is_insert  = (cmd_q == CMD_INSERT);
    eval_take  = is_insert && (rd_entry.mark != MARK_USED);
    eval_match = !is_insert && (rd_entry.mark == MARK_USED) && (rd_entry.key == key_q);
    eval_empty = !is_insert && (rd_entry.mark == MARK_EMPTY);
    eval_last  = (probe_cnt == size_q - 1'b1);
    slot_sum   = {1'b0, slot} + {1'b0, h2};
    if (slot_sum >= {1'b0, size_q}) begin
      slot_adv = SIZE_W'(slot_sum - {1'b0, size_q});
    end else begin
      slot_adv = SIZE_W'(slot_sum);
    end
  end

  // slot memory
  assign slot_addr = IDX_W'(slot);
  assign wr_addr   = (state == ST_CLEAR) ? clr_cnt : slot_addr;

  always_comb begin
    mem_we   = 1'b0;
    wr_entry = '{mark: MARK_EMPTY, key: key_q};
    if (state == ST_CLEAR) begin
      mem_we = 1'b1;
    end else if (state == ST_EVAL) begin
      if (eval_take) begin
        mem_we   = 1'b1;
        wr_entry = '{mark: MARK_USED, key: key_q};
      end else if (eval_match && (cmd_q == CMD_DELETE)) begin
        mem_we   = 1'b1;
        wr_entry = '{mark: MARK_DELETED, key: key_q};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_entry;
    end
    rd_entry <= mem[slot_addr];
  end

  // state machine
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR:  if (clr_cnt == CLR_LAST) state_next = ST_IDLE;
      ST_IDLE: begin
        if (s_accept) begin
          state_next = in_cmd_ok ? ST_HASH : ST_FINISH;
        end
      end
      ST_HASH:   if (hash_done) state_next = ST_REDUCE;
      ST_REDUCE: if (h2 < size_q) state_next = ST_PROBE;
      ST_PROBE:  state_next = ST_EVAL;
      ST_EVAL: begin
        if (eval_take || eval_match || eval_empty || eval_last) begin
          state_next = ST_FINISH;
        end else begin
          state_next = ST_PROBE;
        end
      end
      ST_FINISH: if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (state == ST_CLEAR) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  // request datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (s_accept) begin
          cmd_q    <= cmd_t'(in_cmd);
          key_q    <= in_key;
          size_q   <= eff_size;
          prime_q  <= eff_prime;
          status_q <= STS_NOT_FOUND;
          slot_res <= '0;
        end
      end
      ST_HASH: begin
        if (hash_done) begin
          h2        <= SIZE_W'(prime_q - hash.rp);
          slot      <= hash.h1;
          probe_cnt <= '0;
        end
      end
      ST_REDUCE: begin
        if (h2 >= size_q) begin
          h2 <= h2 - size_q;
        end
      end
      ST_EVAL: begin
        if (eval_take) begin
          status_q <= STS_INSERTED;
          slot_res <= slot;
        end else if (eval_match) begin
          status_q <= (cmd_q == CMD_DELETE) ? STS_DELETED : STS_FOUND;
          slot_res <= slot;
        end else if (eval_empty || eval_last) begin
          status_q <= is_insert ? STS_FULL : STS_NOT_FOUND;
          slot_res <= '0;
        end else begin
          slot      <= slot_adv;
          probe_cnt <= probe_cnt + 1'b1;
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((state == ST_FINISH) && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_FINISH) && out_free) begin
      m_tdata <= {1'b0, SLOT_OUT_W'(slot_res), status_q};
    end
  end

  a_write_states: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == ST_CLEAR || state == ST_EVAL))
    else $error("slot memory written outside clear or evaluation");

  a_probe_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EVAL) |-> (probe_cnt < size_q))
    else $error("probe count beyond table size");

  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PROBE) |-> (slot < size_q))
    else $error("probe slot beyond table size");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> ($past(state) == ST_FINISH))
    else $error("result raised outside finish");

endmodule : double_hash_table_top
`default_nettype wire
